@@ sv/deq_pkg.sv @@
// Shared types and constants for the double-ended queue core.
// Operation and status codes, controller states and the result-load bundle.
// No dependencies.
package deq_pkg;

  // Default number of entries in the circular store
  localparam int DEPTH_DEF = 16;

  // Operation codes carried in in_tuser
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  // Request from the controller to load the output register
  typedef struct packed {
    logic    load;       // load output register this cycle
    logic    from_mem;   // value comes from the store read data
    status_t status;
    logic    has_value;
    logic    last;
  } res_t;

endpackage

@@ sv/double_ended_queue_core.sv @@
// Double-ended queue core. Push, unused codes and a pop or dump of an empty
// queue are handled while idle; a pop from a non-empty queue adds one store
// read, and a dump reads its N entries one after another through the single
// registered read port of the entry store. Pushes and empty reports are valid
// the cycle after accept; a popped or dumped value passes the store's read register, then the output register.
// Synchronous active-low reset empties the queue; store contents stay undefined.
// Depends on deq_pkg, deq_mem and deq_ctrl.
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [2:0]  out_tuser,  // [1:0] status, [2] has_value
  output logic        out_tlast
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic               out_free;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] rd_data;
  res_t               res;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_has_r;
  logic signed [31:0] out_value_r;
  logic               out_last_r;

  assign out_free = !out_valid_r || out_tready;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_value  (in_tdata),
    .out_free  (out_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  deq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (res.load) begin
      out_status_r <= res.status;
      out_has_r    <= res.has_value;
      out_value_r  <= res.from_mem ? rd_data : 32'sd0;
      out_last_r   <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_has_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

@@ sv/deq_mem.sv @@
// Entry store of the double-ended queue: one write port, one read port,
// read data registered (held while no read is issued).
// Depends on deq_pkg for the default depth.
module deq_mem #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [31:0]       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [31:0]       rd_data
);
  import deq_pkg::*;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/deq_ctrl.sv @@
// Controller of the double-ended queue: front pointer, entry count,
// operation decode, store access sequencing and the dump walk.
// Depends on deq_pkg for codes, states and the result-load bundle.
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_func,
  input  logic signed [31:0]       in_value,
  input  logic                     out_free,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic signed [31:0]       mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  output deq_pkg::res_t            res
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  state_t        state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] left_r, left_nxt;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] back_pos;

  // Circular index helpers
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  // Sum stays below twice the depth, so one compare and subtract wraps it
  function automatic logic [AW-1:0] idx_wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return t[AW-1:0];
  endfunction

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  // Slot after the back entry and the back entry itself
  assign tail_sum = SW'(front_r) + SW'(count_r);
  assign back_sum = tail_sum - SW'(1);
  assign tail_pos = idx_wrap(tail_sum);
  assign back_pos = idx_wrap(back_sum);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_empty) begin
          if (in_func == OP_POP_FRONT || in_func == OP_POP_BACK) begin
            state_nxt = S_POP;
          end else if (in_func == OP_DUMP) begin
            state_nxt = S_DUMP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free && left_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Store accesses, pointer updates and result loads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = in_value;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res       = '0;
    front_nxt = front_r;
    count_nxt = count_r;
    walk_nxt  = walk_r;
    left_nxt  = left_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            OP_PUSH_FRONT: begin
              res.load = 1'b1;
              res.last = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                res.status = ST_OK;
                mem_we     = 1'b1;
                mem_waddr  = idx_dec(front_r);
                front_nxt  = idx_dec(front_r);
                count_nxt  = count_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              res.load = 1'b1;
              res.last = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                res.status = ST_OK;
                mem_we     = 1'b1;
                mem_waddr  = tail_pos;
                count_nxt  = count_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res.load   = 1'b1;
                res.last   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                front_nxt = idx_inc(front_r);
                count_nxt = count_r - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res.load   = 1'b1;
                res.last   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = back_pos;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res.load   = 1'b1;
                res.last   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                walk_nxt  = idx_inc(front_r);
                left_nxt  = count_r;
              end
            end
            default: begin
              // unused codes: no result, no change
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          res.load      = 1'b1;
          res.from_mem  = 1'b1;
          res.status    = ST_OK;
          res.has_value = 1'b1;
          res.last      = 1'b1;
        end
      end
      S_DUMP: begin
        // hand out the held entry and fetch the next one in the same cycle
        if (out_free) begin
          res.load      = 1'b1;
          res.from_mem  = 1'b1;
          res.status    = ST_OK;
          res.has_value = 1'b1;
          res.last      = (left_r == CW'(1));
          left_nxt      = left_r - CW'(1);
          if (left_r != CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = walk_r;
            walk_nxt  = idx_inc(walk_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      walk_r  <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule
